[rtl/cfv_pkg.sv]
// Shared types, command codes and frame constants for the command frame validator.
// No dependencies; imported by every module of the block.
package cfv_pkg;

    localparam int CHANNELS     = 4;
    localparam int POINT_MIN    = 2;
    localparam int POINT_MAX    = 8;
    localparam int BUFFER_BYTES = 80;

    localparam int COUNT_W   = 7;
    localparam int HEAD_N    = 4;
    localparam int HEAD_IW   = $clog2(HEAD_N);
    localparam int NEED_W    = 8;
    localparam int POINT_W   = 4;

    localparam logic [7:0] FRAME_HEADER = 8'h68;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_END   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_HEADER  = 3'd1,
        ST_BAD_XOR     = 3'd2,
        ST_UNKNOWN_CMD = 3'd3,
        ST_BAD_LENGTH  = 3'd4
    } status_t;

    localparam logic [7:0] CMD_00 = 8'h00;
    localparam logic [7:0] CMD_02 = 8'h02;
    localparam logic [7:0] CMD_03 = 8'h03;
    localparam logic [7:0] CMD_04 = 8'h04;
    localparam logic [7:0] CMD_05 = 8'h05;
    localparam logic [7:0] CMD_06 = 8'h06;
    localparam logic [7:0] CMD_07 = 8'h07;
    localparam logic [7:0] CMD_08 = 8'h08;
    localparam logic [7:0] CMD_09 = 8'h09;
    localparam logic [7:0] CMD_0A = 8'h0A;
    localparam logic [7:0] CMD_0B = 8'h0B;
    localparam logic [7:0] CMD_0C = 8'h0C;
    localparam logic [7:0] CMD_0E = 8'h0E;
    localparam logic [7:0] CMD_0F = 8'h0F;
    localparam logic [7:0] CMD_10 = 8'h10;
    localparam logic [7:0] CMD_11 = 8'h11;

    // required frame lengths
    localparam logic [NEED_W-1:0] LEN_SHORT    = NEED_W'(3);
    localparam logic [NEED_W-1:0] LEN_BASIC    = NEED_W'(4);
    localparam logic [NEED_W-1:0] LEN_FIVE     = NEED_W'(5);
    localparam logic [NEED_W-1:0] LEN_PERIOD   = NEED_W'(9);
    localparam logic [NEED_W-1:0] LEN_TEN      = NEED_W'(10);
    localparam logic [NEED_W-1:0] LEN_CHANNEL  = NEED_W'(3 + 2 * CHANNELS);
    localparam logic [NEED_W-1:0] LEN_PRESET   = NEED_W'(2 * CHANNELS + 14);
    localparam logic [NEED_W-1:0] POINT_STRIDE = NEED_W'(2 + CHANNELS);
    localparam logic [NEED_W-1:0] POINT_EXTRA  = NEED_W'(4);

    typedef struct packed {
        logic [COUNT_W-1:0]       byte_count;
        logic [7:0]               running_xor;
        logic [HEAD_N-1:0][7:0]   head_bytes;
    } frame_state_t;

endpackage

[rtl/command_frame_validator.sv]
// Top level of the command frame validator: input register, frame tracker,
// checker and result register. Depends on cfv_pkg, cfv_frame_track, cfv_judge.
//
// Usage
//  - Input channel s_*: one item per event. s_operation 0 starts a frame,
//    1 carries s_data_byte, 2 ends the frame. Code 3 is dropped silently.
//  - Result channel m_*: one item per end-of-frame event only, carrying
//    status, command, both argument bytes and the counted length.
//  - cfg_we/cfg_wdata set the dynamic-command enable (reset 1); write only while idle.
//  - Path: an accepted end item goes through the input and result registers to m_*.
//  - Throughput: one item per cycle outside a stall. The input register feeds
//    the frame tracker and checker directly; the result register holds one result.
//  - Stall: while a result waits with m_ready low, start and data items
//    keep flowing; a further end item waits in the input register, and
//    s_ready drops only then.
//  - Reset (aresetn low, synchronous): count, XOR and head bytes clear,
//    both registers empty, the dynamic-command enable returns to one.
//  - Frames shorter than four bytes are judged with head bytes left over
//    from earlier frames, as start does not clear them.
module command_frame_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_command,
    output logic [7:0] m_arg_first,
    output logic [7:0] m_arg_second,
    output logic [6:0] m_frame_length
);
    import cfv_pkg::*;

    // configuration
    logic dyn_en_reg;

    // input stage
    logic       in_valid_reg;
    logic [1:0] op_reg;
    logic [7:0] byte_reg;
    logic       is_end;
    logic       advance;

    // result stage
    logic               out_valid_reg;
    status_t            status_reg;
    logic [7:0]         command_reg;
    logic [7:0]         arg_first_reg;
    logic [7:0]         arg_second_reg;
    logic [COUNT_W-1:0] length_reg;

    frame_state_t frame_state;
    status_t      judge_status;

    assign is_end  = (op_reg == OP_END);
    // only an end item needs the result slot
    assign advance = in_valid_reg && (!is_end || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dyn_en_reg <= 1'b1;
        end else if (cfg_we) begin
            dyn_en_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg   <= s_operation;
            byte_reg <= s_data_byte;
        end
    end

    cfv_frame_track u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .operation   (op_reg),
        .data_byte   (byte_reg),
        .frame_state (frame_state)
    );

    cfv_judge u_judge (
        .frame_state (frame_state),
        .dyn_cmd_en  (dyn_en_reg),
        .status      (judge_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // end events change no state, so the tracker output is the frame as ended
    always_ff @(posedge aclk) begin
        if (advance && is_end) begin
            status_reg     <= judge_status;
            command_reg    <= frame_state.head_bytes[1];
            arg_first_reg  <= frame_state.head_bytes[2];
            arg_second_reg <= frame_state.head_bytes[3];
            length_reg     <= frame_state.byte_count;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_command      = command_reg;
    assign m_arg_first    = arg_first_reg;
    assign m_arg_second   = arg_second_reg;
    assign m_frame_length = length_reg;

    // an end item leaving the input stage always yields a result
    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_end |=> out_valid_reg)
        else $error("end item produced no result");

    // the count never reaches the buffer size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_state.byte_count < COUNT_W'(BUFFER_BYTES))
        else $error("byte count beyond buffer");

    // back-pressure only ever comes from a blocked result slot
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (out_valid_reg && !m_ready && in_valid_reg && is_end))
        else $error("input stalled without a blocked result");

    // a waiting end item is taken the cycle the result slot frees
    a_stall_release: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && is_end && m_ready |-> advance)
        else $error("end item held with result slot free");

endmodule

[rtl/cfv_frame_track.sv]
// Frame tracking registers: byte count, running XOR and the four head bytes.
// Depends on cfv_pkg.
module cfv_frame_track (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [1:0]            operation,
    input  logic [7:0]            data_byte,
    output cfv_pkg::frame_state_t frame_state
);
    import cfv_pkg::*;

    frame_state_t state_reg;
    frame_state_t state_next;
    logic [COUNT_W-1:0] count_inc;

    assign count_inc = state_reg.byte_count + COUNT_W'(1);

    always_comb begin
        state_next = state_reg;
        if (step_en) begin
            unique case (operation)
                OP_START: begin
                    state_next.byte_count  = '0;
                    state_next.running_xor = '0;
                end
                OP_DATA: begin
                    if (state_reg.byte_count < COUNT_W'(HEAD_N)) begin
                        state_next.head_bytes[state_reg.byte_count[HEAD_IW-1:0]] = data_byte;
                    end
                    // wrap at the end of the buffer
                    if (count_inc >= COUNT_W'(BUFFER_BYTES)) begin
                        state_next.byte_count  = '0;
                        state_next.running_xor = '0;
                    end else begin
                        state_next.byte_count  = count_inc;
                        state_next.running_xor = state_reg.running_xor ^ data_byte;
                    end
                end
                default: ; // end of frame and the spare code leave state alone
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign frame_state = state_reg;

endmodule

[rtl/cfv_judge.sv]
// Combinational frame check: header, checksum, command and length.
// Depends on cfv_pkg.
module cfv_judge (
    input  cfv_pkg::frame_state_t frame_state,
    input  logic                  dyn_cmd_en,
    output cfv_pkg::status_t      status
);
    import cfv_pkg::*;

    logic [7:0]        cmd;
    logic [7:0]        points;
    logic [NEED_W-1:0] len;
    logic [NEED_W-1:0] need;
    logic [NEED_W-1:0] point_need;
    logic              known;
    logic              points_ok;

    assign cmd        = frame_state.head_bytes[1];
    assign points     = frame_state.head_bytes[2];
    assign len        = NEED_W'(frame_state.byte_count);
    assign points_ok  = (points >= 8'(POINT_MIN)) && (points <= 8'(POINT_MAX));
    assign point_need = NEED_W'(points[POINT_W-1:0]) * POINT_STRIDE + POINT_EXTRA;

    always_comb begin
        known = 1'b1;
        need  = LEN_BASIC;
        unique case (cmd)
            CMD_02, CMD_03, CMD_06: need = LEN_BASIC;
            CMD_0A: begin
                known = dyn_cmd_en;
                need  = LEN_BASIC;
            end
            CMD_11: begin
                known = dyn_cmd_en;
                need  = LEN_PERIOD;
            end
            CMD_05, CMD_0C, CMD_0F: need = LEN_SHORT;
            CMD_04, CMD_0B:         need = LEN_CHANNEL;
            CMD_07:                 need = LEN_PRESET;
            CMD_08, CMD_09, CMD_00: need = LEN_FIVE;
            CMD_0E:                 need = LEN_TEN;
            CMD_10:                 need = point_need;
            default:                known = 1'b0;
        endcase
    end

    always_comb begin
        priority if (frame_state.head_bytes[0] != FRAME_HEADER) begin
            status = ST_BAD_HEADER;
        end else if (frame_state.running_xor != 8'h00) begin
            status = ST_BAD_XOR;
        end else if (!known) begin
            status = ST_UNKNOWN_CMD;
        end else if (cmd == CMD_10 && !points_ok) begin
            status = ST_BAD_LENGTH;
        end else if (len != need) begin
            status = ST_BAD_LENGTH;
        end else begin
            status = ST_OK;
        end
    end

endmodule

[verif/tb.sv]
// Self-checking testbench for command_frame_validator: directed and random frame traffic,
// with a built-in frame predictor and field-by-field result checks.
// Depends on cfv_pkg and the command_frame_validator RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfv_pkg::*;

    // operation code that the block drops without effect
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // markers returned by needed_length for the cases without a length
    localparam int NEED_UNKNOWN    = -1;
    localparam int NEED_BAD_POINTS = -2;

    localparam int RANDOM_EVENTS = 500;
    localparam int PHASES        = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct packed {
        status_t    status;
        logic [7:0] command;
        logic [7:0] arg_first;
        logic [7:0] arg_second;
        logic [6:0] frame_length;
    } frame_verdict_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation = OP_START;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_status;
    logic [7:0] m_command;
    logic [7:0] m_arg_first;
    logic [7:0] m_arg_second;
    logic [6:0] m_frame_length;

    // predictor state: a copy of what the block tracks between items
    logic [6:0] trk_count = '0;
    logic [7:0] trk_xor = '0;
    logic [7:0] trk_head [HEAD_N] = '{default: 8'h00};
    logic       dyn_en = 1'b1;

    // verdicts for end items accepted but not yet seen on the result side
    frame_verdict_t verdict_q [$];
    frame_verdict_t want;

    bit failed = 1'b0;
    int events_sent = 0;
    int cycle_count = 0;

    // idling controls, shared by the sender, the receiver and the tests
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_cycles = 0;

    command_frame_validator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_command      (m_command),
        .m_arg_first    (m_arg_first),
        .m_arg_second   (m_arg_second),
        .m_frame_length (m_frame_length)
    );

    always #5 aclk = ~aclk;

    // Frame length a command needs. The dynamic-enable gate is not applied
    // here, so stimulus can aim at correct lengths whatever the register holds.
    function automatic int needed_length(input logic [7:0] cmd, input logic [7:0] points);
        case (cmd)
            CMD_02, CMD_03, CMD_06, CMD_0A: return 4;
            CMD_05, CMD_0C, CMD_0F:         return 3;
            CMD_04, CMD_0B:                 return 3 + 2 * CHANNELS;
            CMD_07:                         return 2 * CHANNELS + 14;
            CMD_08, CMD_09, CMD_00:         return 5;
            CMD_0E:                         return 10;
            CMD_11:                         return 9;
            CMD_10: begin
                if (points < POINT_MIN || points > POINT_MAX)
                    return NEED_BAD_POINTS;
                return int'(points) * (2 + CHANNELS) + 4;
            end
            default:                        return NEED_UNKNOWN;
        endcase
    endfunction

    // Checks in the block's order: header, XOR, command, length.
    function automatic status_t judge_frame();
        int need;
        if (trk_head[0] != FRAME_HEADER)
            return ST_BAD_HEADER;
        if (trk_xor != 8'h00)
            return ST_BAD_XOR;
        if (!dyn_en && (trk_head[1] == CMD_0A || trk_head[1] == CMD_11))
            return ST_UNKNOWN_CMD;
        need = needed_length(trk_head[1], trk_head[2]);
        if (need == NEED_UNKNOWN)
            return ST_UNKNOWN_CMD;
        if (need == NEED_BAD_POINTS)
            return ST_BAD_LENGTH;
        return (int'(trk_count) == need) ? ST_OK : ST_BAD_LENGTH;
    endfunction

    // Advances the predictor by one accepted item; end items queue a verdict.
    task automatic track_frame_event(input logic [1:0] op, input logic [7:0] b);
        frame_verdict_t v;
        case (op)
            OP_START: begin
                trk_count = '0;
                trk_xor   = '0;
            end
            OP_DATA: begin
                // only the first four positions land in the head store
                if (trk_count < HEAD_N)
                    trk_head[trk_count[HEAD_IW-1:0]] = b;
                trk_xor   = trk_xor ^ b;
                trk_count = trk_count + 7'd1;
                if (trk_count >= BUFFER_BYTES) begin
                    trk_count = '0;
                    trk_xor   = '0;
                end
            end
            OP_END: begin
                v.status       = judge_frame();
                v.command      = trk_head[1];
                v.arg_first    = trk_head[2];
                v.arg_second   = trk_head[3];
                v.frame_length = trk_count;
                verdict_q.push_back(v);
            end
            default: ;  // unused code: nothing changes
        endcase
    endtask

    function automatic logic [7:0] known_cmd(input int k);
        case (k)
            0:       return CMD_00;
            1:       return CMD_02;
            2:       return CMD_03;
            3:       return CMD_04;
            4:       return CMD_05;
            5:       return CMD_06;
            6:       return CMD_07;
            7:       return CMD_08;
            8:       return CMD_09;
            9:       return CMD_0A;
            10:      return CMD_0B;
            11:      return CMD_0C;
            12:      return CMD_0E;
            13:      return CMD_0F;
            14:      return CMD_10;
            default: return CMD_11;
        endcase
    endfunction

    // Offers one item after a random gap and returns at the edge that takes it.
    // Called and returning on a rising-edge time step; valid is only lowered
    // when a gap follows, so it never toggles twice in one step.
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        track_frame_event(op, b);
        if (op != OP_UNUSED)
            events_sent++;
    endtask

    // Sends a whole frame: optional start, len data bytes, end.
    // Bytes 0..2 are header, command and point count/first argument; with
    // four or more bytes the last one is set to make the XOR zero or non-zero.
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] points, input int len,
                              input bit hdr_ok, input bit xor_ok, input bit with_start);
        logic [7:0] body [$];
        logic [7:0] b;
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < len; i++) begin
            case (i)
                0: begin
                    b = 8'($urandom_range(0, 255));
                    if (hdr_ok)
                        b = FRAME_HEADER;
                    else if (b == FRAME_HEADER)
                        b = ~b;
                end
                1:       b = cmd;
                2:       b = points;
                default: b = 8'($urandom_range(0, 255));
            endcase
            body.push_back(b);
            sum = sum ^ b;
        end
        if (len >= HEAD_N) begin
            if (xor_ok)
                body[len-1] = body[len-1] ^ sum;
            else if (sum == 8'h00)
                body[len-1] = body[len-1] ^ 8'($urandom_range(1, 255));
        end
        if (with_start)
            send_item(OP_START, 8'($urandom_range(0, 255)));
        foreach (body[i])
            send_item(OP_DATA, body[i]);
        send_item(OP_END, 8'($urandom_range(0, 255)));
    endtask

    // Stops offering, waits for every outstanding verdict, then lets the
    // pipeline settle (start/data items may still sit in the input register).
    task automatic drain_results();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Only called with the block idle; waits with cfg_we low before it returns, so that
    // back-to-back writes never raise and lower the enable in one step.
    task automatic write_dynamic(input logic v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        dyn_en = v;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Right after reset: unused code is dropped, end sees the cleared head
    // store (bad header, zero fields).
    task automatic test_after_reset();
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_END, 8'hFF);
        send_item(OP_START, 8'hFF);
        send_item(OP_END, 8'h00);
    endtask

    // Every known command with its correct length; the first argument alternates
    // all-zeros and all-ones, and the point command uses its largest count.
    task automatic test_command_set();
        logic [7:0] cmd;
        logic [7:0] points;
        for (int k = 0; k < 16; k++) begin
            cmd    = known_cmd(k);
            points = (cmd == CMD_10) ? 8'(POINT_MAX) : ((k % 2) ? 8'hFF : 8'h00);
            send_frame(cmd, points, needed_length(cmd, points), 1'b1, 1'b1, 1'b1);
        end
    endtask

    // One frame per failure status, plus frames too short to fill the head.
    task automatic test_bad_frames();
        send_frame(CMD_02, 8'h11, 4, 1'b0, 1'b1, 1'b1);
        send_frame(CMD_02, 8'h22, 4, 1'b1, 1'b0, 1'b1);
        send_frame(8'hFF, 8'h33, 4, 1'b1, 1'b1, 1'b1);
        send_frame(CMD_02, 8'h44, 5, 1'b1, 1'b1, 1'b1);
        send_frame(CMD_03, 8'h55, 2, 1'b1, 1'b1, 1'b1);
        send_frame(CMD_03, 8'h66, 1, 1'b1, 1'b1, 1'b1);
    endtask

    // Start keeps the head bytes, and an end changes nothing, so two ends
    // on an empty frame report the same stale command and arguments.
    task automatic test_stale_head();
        send_frame(CMD_05, 8'hA5, 3, 1'b1, 1'b1, 1'b1);
        send_item(OP_START, 8'hFF);
        send_item(OP_END, 8'h00);
        send_item(OP_END, 8'hFF);
        send_item(OP_DATA, FRAME_HEADER);
        send_item(OP_END, 8'h5A);
    endtask

    // Point command: counts either side of the allowed range, the lower bound and all ones.
    task automatic test_point_count();
        send_frame(CMD_10, 8'(POINT_MIN - 1), 4, 1'b1, 1'b1, 1'b1);
        send_frame(CMD_10, 8'(POINT_MAX + 1),
                   (POINT_MAX + 1) * (2 + CHANNELS) + 4, 1'b1, 1'b1, 1'b1);
        send_frame(CMD_10, 8'(POINT_MIN), needed_length(CMD_10, 8'(POINT_MIN)),
                   1'b1, 1'b1, 1'b1);
        send_frame(CMD_10, 8'hFF, 6, 1'b1, 1'b1, 1'b1);
    endtask

    // Longest count before the wrap, then the wrap itself, after which the
    // next bytes refill the head store without a start.
    task automatic test_wrap();
        send_item(OP_START, 8'h00);
        send_item(OP_DATA, FRAME_HEADER);
        send_item(OP_DATA, CMD_07);
        for (int i = 2; i < BUFFER_BYTES - 1; i++)
            send_item(OP_DATA, 8'($urandom_range(0, 255)));
        send_item(OP_END, 8'h00);
        send_item(OP_DATA, 8'($urandom_range(0, 255)));
        send_item(OP_DATA, FRAME_HEADER);
        send_item(OP_DATA, CMD_05);
        send_item(OP_DATA, FRAME_HEADER ^ CMD_05);
        send_item(OP_END, 8'hFF);
    endtask

    // Dynamic commands are refused with the register clear, taken with it set.
    task automatic test_dyn_commands();
        for (int pass = 0; pass < 2; pass++) begin
            drain_results();
            write_dynamic(pass[0]);
            send_frame(CMD_0A, 8'h01, needed_length(CMD_0A, 8'h01), 1'b1, 1'b1, 1'b1);
            send_frame(CMD_11, 8'h02, needed_length(CMD_11, 8'h02), 1'b1, 1'b1, 1'b1);
        end
    endtask

    // Receiver holds off for a long stretch after the next result while the
    // sender streams short frames: the result register and the input
    // register fill and the block has to drop s_ready.
    task automatic test_backpressure();
        drain_results();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_frame(CMD_05, 8'($urandom_range(0, 255)), 3, 1'b1, 1'b1, 1'b1);
        drain_results();
        tx_idle_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content, some broken ones and
    // some loose noise items. Each phase sets the register and its own
    // idling mix; two phases run one side flat out.
    task automatic test_random_traffic();
        int target;
        int need;
        int len;
        int r;
        logic [7:0] cmd;
        logic [7:0] points;
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            write_dynamic((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 3);
            target = events_sent + RANDOM_EVENTS / PHASES;
            while (events_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end else begin
                    cmd = ($urandom_range(0, 99) < 75) ? known_cmd($urandom_range(0, 15))
                                                       : 8'($urandom_range(0, 255));
                    points = 8'($urandom_range(0, 255));
                    if (cmd == CMD_10 && $urandom_range(0, 99) < 80)
                        points = 8'($urandom_range(POINT_MIN - 1, POINT_MAX + 1));
                    need = needed_length(cmd, points);
                    r = $urandom_range(0, 99);
                    if (need > 0 && r < 75)
                        len = need;
                    else if (r < 80)
                        len = $urandom_range(60, 95);   // may run through the wrap
                    else
                        len = $urandom_range(0, 24);
                    send_frame(cmd, points, len, $urandom_range(0, 99) < 90,
                               $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 92);
                end
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ---------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------

    // Receiver: draws a stall per item, or takes a pending long hold-off.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compares each taken result with the oldest verdict, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("result item with no verdict pending");
                failed = 1'b1;
            end else begin
                want = verdict_q.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    failed = 1'b1;
                end
                if (m_command !== want.command) begin
                    $error("command: expected %0h, got %0h", want.command, m_command);
                    failed = 1'b1;
                end
                if (m_arg_first !== want.arg_first) begin
                    $error("arg_first: expected %0h, got %0h", want.arg_first, m_arg_first);
                    failed = 1'b1;
                end
                if (m_arg_second !== want.arg_second) begin
                    $error("arg_second: expected %0h, got %0h",
                           want.arg_second, m_arg_second);
                    failed = 1'b1;
                end
                if (m_frame_length !== want.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, m_frame_length);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: covers a hung handshake or a verdict that never arrives.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_after_reset();
        test_command_set();
        test_bad_frames();
        test_stale_head();
        test_point_count();
        test_wrap();
        test_dyn_commands();
        test_backpressure();
        test_random_traffic();
        drain_results();
        if (failed || verdict_q.size() != 0)
            $display("TB_ERROR");
        else
            $display("TB_OK");
        $finish;
    end

endmodule
